// ===== sv/assert_macros.svh =====
// Assertion helpers for the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/v3mn_pkg.sv =====
package v3mn_pkg;
    localparam int COMPONENT_WIDTH_DEF = 32;
    localparam int LENGTH_WIDTH        = 32;
    localparam int UNIT_WIDTH          = 32;
    localparam int FRAC_UNIT           = 30;
endpackage

// ===== sv/v3mn_sumsq.sv =====
// Magnitudes and exact sum of squares, two register stages.
module v3mn_sumsq
    import v3mn_pkg::*;
#(
    parameter int CW = COMPONENT_WIDTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                in_valid,
    input  logic [CW-1:0]       in_x,
    input  logic [CW-1:0]       in_y,
    input  logic [CW-1:0]       in_z,
    output logic                out_valid,
    output logic [2*CW+1:0]     out_sum,
    output logic [CW-1:0]       out_mx,
    output logic [CW-1:0]       out_my,
    output logic [CW-1:0]       out_mz,
    output logic [2:0]          out_neg
);
    logic [CW-1:0]   ma_reg, mb_reg, mc_reg;
    logic [2:0]      na_reg;
    logic            va_reg;
    logic [CW-1:0]   mx_reg, my_reg, mz_reg;
    logic [2:0]      nb_reg;
    logic            vb_reg;
    logic [2*CW+1:0] sum_reg;
    logic [2*CW+1:0] sum_next;
    logic [2*CW-1:0] sqa, sqb, sqc;

    function automatic logic [CW-1:0] abs_c(input logic [CW-1:0] v);
        abs_c = v[CW-1] ? (~v + 1'b1) : v;
    endfunction

    // full-width squares
    assign sqa = ma_reg * ma_reg;
    assign sqb = mb_reg * mb_reg;
    assign sqc = mc_reg * mc_reg;

    assign sum_next = {2'b00, sqa} + {2'b00, sqb} + {2'b00, sqc};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end else if (en) begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
        end
        if (en) begin
            ma_reg  <= abs_c(in_x);
            mb_reg  <= abs_c(in_y);
            mc_reg  <= abs_c(in_z);
            na_reg  <= {in_z[CW-1], in_y[CW-1], in_x[CW-1]};
            sum_reg <= sum_next;
            mx_reg  <= ma_reg;
            my_reg  <= mb_reg;
            mz_reg  <= mc_reg;
            nb_reg  <= na_reg;
        end
    end

    assign out_valid = vb_reg;
    assign out_sum   = sum_reg;
    assign out_mx    = mx_reg;
    assign out_my    = my_reg;
    assign out_mz    = mz_reg;
    assign out_neg   = nb_reg;
endmodule

// ===== sv/v3mn_sqrt.sv =====
// Pipelined digit-by-digit square root, one result bit per stage.
module v3mn_sqrt
    import v3mn_pkg::*;
#(
    parameter int CW = COMPONENT_WIDTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                in_valid,
    input  logic [2*CW+1:0]     in_sum,
    input  logic [CW-1:0]       in_mx,
    input  logic [CW-1:0]       in_my,
    input  logic [CW-1:0]       in_mz,
    input  logic [2:0]          in_neg,
    output logic                out_valid,
    output logic [CW:0]         out_root,
    output logic [CW-1:0]       out_mx,
    output logic [CW-1:0]       out_my,
    output logic [CW-1:0]       out_mz,
    output logic [2:0]          out_neg
);
    localparam int NS = CW + 1;
    localparam int SW = 2 * NS;

    logic [SW-1:0] s_reg    [NS];
    logic [NS+1:0] rem_reg  [NS];
    logic [NS-1:0] root_reg [NS];
    logic [CW-1:0] mx_reg   [NS];
    logic [CW-1:0] my_reg   [NS];
    logic [CW-1:0] mz_reg   [NS];
    logic [2:0]    n_reg    [NS];
    logic [NS-1:0] v_reg;

    genvar g;
    generate
        for (g = 0; g < NS; g++) begin : g_stage
            logic [SW-1:0] s_in;
            logic [NS+1:0] rem_in;
            logic [NS-1:0] root_in;
            logic          v_in;
            logic [CW-1:0] mx_in, my_in, mz_in;
            logic [2:0]    n_in;
            logic [NS+1:0] rem_sh, trial, rem_next;
            logic [NS-1:0] root_next;
            if (g == 0) begin : g_first
                assign s_in    = in_sum;
                assign rem_in  = '0;
                assign root_in = '0;
                assign v_in    = in_valid;
                assign mx_in   = in_mx;
                assign my_in   = in_my;
                assign mz_in   = in_mz;
                assign n_in    = in_neg;
            end else begin : g_rest
                assign s_in    = s_reg[g-1];
                assign rem_in  = rem_reg[g-1];
                assign root_in = root_reg[g-1];
                assign v_in    = v_reg[g-1];
                assign mx_in   = mx_reg[g-1];
                assign my_in   = my_reg[g-1];
                assign mz_in   = mz_reg[g-1];
                assign n_in    = n_reg[g-1];
            end
            always_comb begin
                rem_sh = {rem_in[NS-1:0], s_in[SW-1:SW-2]};
                trial  = {root_in, 2'b01};
                if (rem_sh >= trial) begin
                    rem_next  = rem_sh - trial;
                    root_next = {root_in[NS-2:0], 1'b1};
                end else begin
                    rem_next  = rem_sh;
                    root_next = {root_in[NS-2:0], 1'b0};
                end
            end
            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    v_reg[g] <= 1'b0;
                end else if (en) begin
                    v_reg[g] <= v_in;
                end
                if (en) begin
                    s_reg[g]    <= {s_in[SW-3:0], 2'b00};
                    rem_reg[g]  <= rem_next;
                    root_reg[g] <= root_next;
                    mx_reg[g]   <= mx_in;
                    my_reg[g]   <= my_in;
                    mz_reg[g]   <= mz_in;
                    n_reg[g]    <= n_in;
                end
            end
        end
    endgenerate

    assign out_valid = v_reg[NS-1];
    assign out_root  = root_reg[NS-1];
    assign out_mx    = mx_reg[NS-1];
    assign out_my    = my_reg[NS-1];
    assign out_mz    = mz_reg[NS-1];
    assign out_neg   = n_reg[NS-1];
endmodule

// ===== sv/v3mn_div.sv =====
// Pipelined restoring divider for the three unit components, one
// quotient bit per stage for all three lanes at once.
module v3mn_div
    import v3mn_pkg::*;
#(
    parameter int CW = COMPONENT_WIDTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic [CW:0]           in_len,
    input  logic [CW-1:0]         in_mx,
    input  logic [CW-1:0]         in_my,
    input  logic [CW-1:0]         in_mz,
    input  logic [2:0]            in_neg,
    output logic                  out_valid,
    output logic [CW:0]           out_len,
    output logic [3*(FRAC_UNIT+1)-1:0] out_q,
    output logic [2:0]            out_neg,
    output logic                  out_zero
);
    localparam int NS = FRAC_UNIT + 1;   // quotient bit 30 down to 0
    localparam int RW = CW + 2;

    logic [CW:0]   len_reg [NS];
    logic [RW-1:0] r_reg   [NS][3];
    logic [NS-1:0] q_reg   [NS][3];
    logic [2:0]    n_reg   [NS];
    logic [NS-1:0] v_reg;

    genvar g, l;
    generate
        for (g = 0; g < NS; g++) begin : g_stage
            logic [CW:0] len_in;
            logic        v_in;
            logic [2:0]  n_in;
            if (g == 0) begin : g_first
                assign len_in = in_len;
                assign v_in   = in_valid;
                assign n_in   = in_neg;
            end else begin : g_rest
                assign len_in = len_reg[g-1];
                assign v_in   = v_reg[g-1];
                assign n_in   = n_reg[g-1];
            end
            for (l = 0; l < 3; l++) begin : g_lane
                logic [RW-1:0] r_in, r_sh;
                logic [NS-1:0] q_in;
                if (g == 0) begin : g_first
                    // first step compares mag itself (quotient bit FRAC_UNIT)
                    assign r_in = (l == 0) ? {2'b00, in_mx}
                                : (l == 1) ? {2'b00, in_my} : {2'b00, in_mz};
                    assign q_in = '0;
                    assign r_sh = r_in;
                end else begin : g_rest
                    assign r_in = r_reg[g-1][l];
                    assign q_in = q_reg[g-1][l];
                    assign r_sh = {r_in[RW-2:0], 1'b0};
                end
                always_ff @(posedge aclk) begin
                    if (en) begin
                        if (r_sh >= {1'b0, len_in}) begin
                            r_reg[g][l] <= r_sh - {1'b0, len_in};
                            q_reg[g][l] <= {q_in[NS-2:0], 1'b1};
                        end else begin
                            r_reg[g][l] <= r_sh;
                            q_reg[g][l] <= {q_in[NS-2:0], 1'b0};
                        end
                    end
                end
            end
            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    v_reg[g] <= 1'b0;
                end else if (en) begin
                    v_reg[g] <= v_in;
                end
                if (en) begin
                    len_reg[g] <= len_in;
                    n_reg[g]   <= n_in;
                end
            end
        end
    endgenerate

    assign out_valid = v_reg[NS-1];
    assign out_len   = len_reg[NS-1];
    assign out_q     = {q_reg[NS-1][2], q_reg[NS-1][1], q_reg[NS-1][0]};
    assign out_neg   = n_reg[NS-1];
    assign out_zero  = (len_reg[NS-1] == '0);
endmodule

// ===== sv/vector3_magnitude_normalize.sv =====
// Pipeline from accept to result: 2 magnitude/square stages, one sqrt stage
// per root bit, 31 divide stages, one output register. Throughput: one vector
// per cycle; the whole pipeline advances whenever the output register is free
// or being drained.
// Reset: synchronous active-low aresetn clears all valid bits.
`include "assert_macros.svh"
module vector3_magnitude_normalize
    import v3mn_pkg::*;
#(
    parameter int COMPONENT_WIDTH = COMPONENT_WIDTH_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [COMPONENT_WIDTH-1:0] s_in_x,
    input  logic [COMPONENT_WIDTH-1:0] s_in_y,
    input  logic [COMPONENT_WIDTH-1:0] s_in_z,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [LENGTH_WIDTH-1:0]    m_length,
    output logic [UNIT_WIDTH-1:0]      m_unit_x,
    output logic [UNIT_WIDTH-1:0]      m_unit_y,
    output logic [UNIT_WIDTH-1:0]      m_unit_z,
    output logic                       m_zero_vector
);
    localparam int CW = COMPONENT_WIDTH;
    localparam int QW = FRAC_UNIT + 1;

    logic en;
    logic a_v, b_v, c_v;
    logic [2*CW+1:0] a_sum;
    logic [CW-1:0] a_mx, a_my, a_mz, b_mx, b_my, b_mz;
    logic [2:0] a_n, b_n, c_n;
    logic [CW:0] b_root, c_len;
    logic [3*QW-1:0] c_q;
    logic c_zero;

    logic m_valid_reg;
    logic [LENGTH_WIDTH-1:0] len_reg;
    logic [UNIT_WIDTH-1:0] ux_reg, uy_reg, uz_reg;
    logic zero_reg;

    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    v3mn_sumsq #(.CW(CW)) u_sumsq (
        .aclk, .aresetn, .en,
        .in_valid(s_valid && s_ready),
        .in_x(s_in_x), .in_y(s_in_y), .in_z(s_in_z),
        .out_valid(a_v), .out_sum(a_sum),
        .out_mx(a_mx), .out_my(a_my), .out_mz(a_mz), .out_neg(a_n)
    );

    v3mn_sqrt #(.CW(CW)) u_sqrt (
        .aclk, .aresetn, .en,
        .in_valid(a_v), .in_sum(a_sum),
        .in_mx(a_mx), .in_my(a_my), .in_mz(a_mz), .in_neg(a_n),
        .out_valid(b_v), .out_root(b_root),
        .out_mx(b_mx), .out_my(b_my), .out_mz(b_mz), .out_neg(b_n)
    );

    v3mn_div #(.CW(CW)) u_div (
        .aclk, .aresetn, .en,
        .in_valid(b_v), .in_len(b_root),
        .in_mx(b_mx), .in_my(b_my), .in_mz(b_mz), .in_neg(b_n),
        .out_valid(c_v), .out_len(c_len), .out_q(c_q),
        .out_neg(c_n), .out_zero(c_zero)
    );

    function automatic logic [UNIT_WIDTH-1:0] signed_unit(
        input logic [QW-1:0] q, input logic neg, input logic zero);
        logic [UNIT_WIDTH-1:0] u;
        u = UNIT_WIDTH'(q);
        if (zero)
            signed_unit = '0;
        else
            signed_unit = neg ? (~u + 1'b1) : u;
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= c_v;
        end
        if (en) begin
            len_reg  <= LENGTH_WIDTH'(c_len);
            ux_reg   <= signed_unit(c_q[QW-1:0], c_n[0], c_zero);
            uy_reg   <= signed_unit(c_q[2*QW-1:QW], c_n[1], c_zero);
            uz_reg   <= signed_unit(c_q[3*QW-1:2*QW], c_n[2], c_zero);
            zero_reg <= c_zero;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_length      = len_reg;
    assign m_unit_x      = ux_reg;
    assign m_unit_y      = uy_reg;
    assign m_unit_z      = uz_reg;
    assign m_zero_vector = zero_reg;

    `ASSERT_IMPL(a_zero_units, aclk, aresetn, m_valid && m_zero_vector,
        m_unit_x == '0 && m_unit_y == '0 && m_unit_z == '0 && m_length == '0,
        "zero vector with nonzero outputs")
    `ASSERT_IMPL(a_zero_flag, aclk, aresetn, m_valid && m_length == '0,
        m_zero_vector, "zero length without zero flag")
    `ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready,
        m_valid && $stable(m_length) && $stable(m_unit_x),
        "result changed while stalled")
endmodule

// ===== bench/vector3_magnitude_normalize_test.sv =====
`timescale 1ns / 100ps

module vector3_magnitude_normalize_test
    import v3mn_pkg::*;
;

    localparam int CW = COMPONENT_WIDTH_DEF;
    localparam int PIPE_DEPTH = CW + 35;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [LENGTH_WIDTH-1:0] length;
        logic [UNIT_WIDTH-1:0]   unit_x;
        logic [UNIT_WIDTH-1:0]   unit_y;
        logic [UNIT_WIDTH-1:0]   unit_z;
        logic                    zero_vector;
    } norm_result_t;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    logic [CW-1:0] s_in_x, s_in_y, s_in_z;
    logic m_valid;
    logic m_ready;
    logic [LENGTH_WIDTH-1:0] m_length;
    logic [UNIT_WIDTH-1:0] m_unit_x, m_unit_y, m_unit_z;
    logic m_zero_vector;

    norm_result_t expected_norms[$];
    int mismatch_count;
    longint cycle_count;
    bit sink_stall_enable;
    bit source_idle_enable;

    vector3_magnitude_normalize #(.COMPONENT_WIDTH(CW)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_in_x(s_in_x), .s_in_y(s_in_y), .s_in_z(s_in_z),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_length(m_length), .m_unit_x(m_unit_x), .m_unit_y(m_unit_y),
        .m_unit_z(m_unit_z), .m_zero_vector(m_zero_vector)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // floor sqrt of a 128-bit sum, digit by digit
    function automatic logic [63:0] floor_sqrt(input logic [127:0] sum);
        logic [129:0] rem;
        logic [129:0] trial;
        logic [63:0] root;
        rem = '0;
        root = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = (rem << 2) | sum[2*i +: 2];
            trial = {root, 2'b01};
            if (rem >= trial) begin
                rem = rem - trial;
                root = {root[62:0], 1'b1};
            end else begin
                root = {root[62:0], 1'b0};
            end
        end
        return root;
    endfunction

    function automatic norm_result_t normalize_vector(input logic [CW-1:0] x,
                                                      input logic [CW-1:0] y,
                                                      input logic [CW-1:0] z);
        logic [CW-1:0] comp[3];
        logic [63:0] mag[3];
        logic [127:0] sum;
        logic [63:0] len;
        logic [127:0] quo;
        logic [31:0] q;
        norm_result_t r;
        comp[0] = x;
        comp[1] = y;
        comp[2] = z;
        sum = '0;
        for (int i = 0; i < 3; i++) begin
            mag[i] = comp[i][CW-1] ? 64'(-comp[i]) : 64'(comp[i]);
            mag[i] = mag[i] & ((64'd1 << CW) - 1);
            sum = sum + 128'(mag[i]) * 128'(mag[i]);
        end
        len = floor_sqrt(sum);
        r = '0;
        r.length = len[LENGTH_WIDTH-1:0];
        if (len == 0) begin
            r.zero_vector = 1'b1;
            return r;
        end
        for (int i = 0; i < 3; i++) begin
            quo = (128'(mag[i]) << FRAC_UNIT) / 128'(len);
            q = quo[31:0];
            if (comp[i][CW-1]) q = -q;
            case (i)
                0: r.unit_x = q;
                1: r.unit_y = q;
                default: r.unit_z = q;
            endcase
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want,
                 cycle_count);
        mismatch_count++;
    endtask

    // valid stays high between back-to-back transactions; this task drops it only while idling
    task automatic send_vector(input logic [CW-1:0] x, input logic [CW-1:0] y,
                               input logic [CW-1:0] z);
        while (source_idle_enable && $urandom_range(99) < 18) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_in_x <= x;
        s_in_y <= y;
        s_in_z <= z;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        expected_norms.push_back(normalize_vector(x, y, z));
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (expected_norms.size() != 0) @(posedge aclk);
    endtask

    function automatic logic [CW-1:0] random_component();
        case ($urandom_range(5))
            0: return CW'($signed($urandom_range(4)) - 2);
            1: return {1'b1, {(CW-1){1'b0}}};
            2: return {1'b0, {(CW-1){1'b1}}};
            3: return CW'($signed($urandom_range(65535 * 4)) - 131072);
            default: return CW'($urandom);
        endcase
    endfunction

    // result checker
    always @(posedge aclk) begin
        norm_result_t want;
        cycle_count <= cycle_count + 1;
        if (aresetn && m_valid && m_ready) begin
            if (expected_norms.size() == 0) begin
                report_mismatch("unexpected transaction", m_length, 32'd0);
            end else begin
                want = expected_norms.pop_front();
                if (m_length !== want.length)
                    report_mismatch("length", m_length, want.length);
                if (m_unit_x !== want.unit_x)
                    report_mismatch("unit_x", m_unit_x, want.unit_x);
                if (m_unit_y !== want.unit_y)
                    report_mismatch("unit_y", m_unit_y, want.unit_y);
                if (m_unit_z !== want.unit_z)
                    report_mismatch("unit_z", m_unit_z, want.unit_z);
                if (m_zero_vector !== want.zero_vector)
                    report_mismatch("zero_vector", 32'(m_zero_vector),
                                    32'(want.zero_vector));
            end
        end
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    always @(posedge aclk) begin
        m_ready <= !(sink_stall_enable && $urandom_range(99) < 18);
    end

    task automatic test_extremes();
        logic [CW-1:0] vals[6];
        vals[0] = '0;
        vals[1] = {1'b1, {(CW-1){1'b0}}};
        vals[2] = {1'b0, {(CW-1){1'b1}}};
        vals[3] = '1;
        vals[4] = CW'(1);
        vals[5] = CW'(32'h0001_0000);
        send_vector(vals[0], vals[0], vals[0]);
        send_vector(vals[1], vals[1], vals[1]);
        send_vector(vals[2], vals[2], vals[2]);
        send_vector(vals[1], vals[2], '0);
        send_vector(vals[3], '0, '0);
        send_vector('0, vals[4], '0);
        send_vector('0, '0, vals[3]);
        send_vector(vals[5], vals[5], '0);
        send_vector(vals[5], '0, '0);
        send_vector(vals[4], vals[3], vals[4]);
        send_vector(vals[1], '0, '0);
        send_vector(CW'(32'hAAAA_AAAA), CW'(32'h5555_5555), CW'(32'h0F0F_F0F0));
    endtask

    task automatic test_planar_vectors();
        for (int i = 0; i < 8; i++)
            send_vector(random_component(), random_component(), '0);
        drain_results();
    endtask

    task automatic test_random_vectors(input int count);
        for (int i = 0; i < count; i++)
            send_vector(random_component(), random_component(), random_component());
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_in_x = '0;
        s_in_y = '0;
        s_in_z = '0;
        m_ready = 1'b0;
        mismatch_count = 0;
        cycle_count = 0;
        sink_stall_enable = 1'b1;
        source_idle_enable = 1'b1;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_extremes();
        test_planar_vectors();
        test_random_vectors(400);
        // back-to-back stretch without idling or sink stalls
        sink_stall_enable = 1'b0;
        source_idle_enable = 1'b0;
        test_random_vectors(300);
        sink_stall_enable = 1'b1;
        source_idle_enable = 1'b1;
        test_random_vectors(380);

        drain_results();
        repeat (PIPE_DEPTH + 10) @(posedge aclk);
        if (mismatch_count == 0 && expected_norms.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
